// ===== rtl/core/hbkrb_pkg.sv =====
// Package for the HID boot keyboard report builder: sizes, key codes,
// shared types and the lock report slot function.
// No dependencies.
`timescale 1ns / 1ps

package hbkrb_pkg;

   // Number of keys tracked in the pressed-key bitmap.
   localparam int KEY_COUNT    = 102;
   // Number of report slots that carry key codes.
   localparam int REPORT_SLOTS = 6;
   // Number of slot ports on the report interface.
   localparam int SLOT_PORTS   = 6;

   localparam int KEY_IDX_W = $clog2(KEY_COUNT);
   localparam int CNT_W     = $clog2(REPORT_SLOTS + 1);

   typedef logic [7:0] code_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;

   // Key codes used in reports.
   localparam code_type EMPTY_CODE     = 8'h00;
   localparam code_type ROLLOVER_CODE  = 8'h01;
   localparam code_type CAPS_LOCK_CODE = 8'd57;
   localparam code_type NUM_LOCK_CODE  = 8'd83;
   localparam code_type MOD_FIRST      = 8'd224;
   localparam code_type MOD_LAST       = 8'd231;

   // Write port of the pressed-key bitmap.
   typedef struct packed {
      logic        en;
      key_idx_type addr;
      logic        data;
   } map_wr_type;

   // Slot contents of the lock report: caps lock first, then num lock,
   // packed from slot zero and limited to the active slots.
   function automatic code_type lock_slot(input int s, input logic caps, input logic num);
      code_type code;
      code = EMPTY_CODE;
      if (s < REPORT_SLOTS) begin
         if (s == 0) begin
            if (caps) begin
               code = CAPS_LOCK_CODE;
            end else if (num) begin
               code = NUM_LOCK_CODE;
            end
         end else if (s == 1) begin
            if (caps && num) begin
               code = NUM_LOCK_CODE;
            end
         end
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/hbkrb_keymap.sv =====
// Pressed-key bitmap for the HID boot keyboard report builder: a one-bit
// memory with one write port and one registered read port.
// Depends on hbkrb_pkg.
`timescale 1ns / 1ps

module hbkrb_keymap (
   input  logic                 clock,
   input  logic                 reset,
   input  hbkrb_pkg::map_wr_type wr,
   input  hbkrb_pkg::key_idx_type rd_addr,
   output logic                 rd_data
);

   logic mem [hbkrb_pkg::KEY_COUNT];
   logic [hbkrb_pkg::KEY_COUNT-1:0] vld_ff;
   logic [hbkrb_pkg::KEY_COUNT-1:0] vld_in;
   logic rd_mem_ff;
   logic rd_vld_ff;

   // Memory write; entries never written read as released.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read of the memory.
   always_ff @(posedge clock) begin
      rd_mem_ff <= mem[rd_addr];
   end

   // Per-entry valid bits, cleared at reset.
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_mem_ff & rd_vld_ff;

endmodule

// ===== rtl/core/hid_boot_keyboard_report_builder.sv =====
// HID boot keyboard report builder: top level with the scan sequencer and
// report output registers. Depends on hbkrb_pkg and hbkrb_keymap.
`timescale 1ns / 1ps

// Each key event request updates a pressed-key bitmap and produces one
// boot keyboard report (modifier byte plus six key slots listed in
// ascending order, or all 0x01 when more than six keys are held). The
// first event after reset that is not dropped is preceded by a lock
// report when caps or num lock is on; it has last low. Repeats and
// scancodes that are neither keys (below 102) nor modifiers (224 to 231)
// are dropped. For a reported event, the first report follows a bitmap
// scan that reads one entry per cycle through the single read port of
// the bitmap memory. A new request is taken only after the last report
// of the previous one has been delivered.
module hid_boot_keyboard_report_builder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_scancode,
   input  logic        req_key_down,
   input  logic        req_is_repeat,
   input  logic [7:0]  req_modifier_bits,
   input  logic        req_caps_lock_on,
   input  logic        req_num_lock_on,
   input  logic [63:0] req_ack_wait,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_report_modifiers,
   output logic [7:0]  rsp_slot0,
   output logic [7:0]  rsp_slot1,
   output logic [7:0]  rsp_slot2,
   output logic [7:0]  rsp_slot3,
   output logic [7:0]  rsp_slot4,
   output logic [7:0]  rsp_slot5,
   output logic [63:0] rsp_report_ack_wait,
   output logic        rsp_last
);

   localparam int SP = hbkrb_pkg::SLOT_PORTS;
   localparam int KW = hbkrb_pkg::KEY_IDX_W;
   localparam int CW = hbkrb_pkg::CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LOCK = 2'd2;
   localparam logic [1:0] ST_KEY  = 2'd3;

   localparam hbkrb_pkg::key_idx_type LAST_IDX = KW'(hbkrb_pkg::KEY_COUNT - 1);

   logic [1:0] state_ff, state_in;
   logic       synced_ff, synced_in;
   logic       lock_pend_ff, lock_pend_in;
   logic       caps_ff, caps_in;
   logic       num_ff, num_in;
   logic [7:0] mods_ff, mods_in;
   logic [63:0] ack_ff, ack_in;

   hbkrb_pkg::key_idx_type idx_ff, idx_in;
   logic       issue_done_ff, issue_done_in;
   logic       dat_vld_ff, dat_vld_in;
   hbkrb_pkg::key_idx_type dat_idx_ff, dat_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic       rollover_ff, rollover_in;
   hbkrb_pkg::code_type key_slot_ff [SP];
   hbkrb_pkg::code_type key_slot_in [SP];

   logic [7:0]  out_mods_ff, out_mods_in;
   hbkrb_pkg::code_type out_slot_ff [SP];
   hbkrb_pkg::code_type out_slot_in [SP];
   logic [63:0] out_ack_ff, out_ack_in;
   logic        out_last_ff, out_last_in;

   logic accept;
   logic is_mod;
   logic is_key;
   logic ignored;
   logic scan_end;
   logic rd_data;
   hbkrb_pkg::map_wr_type map_wr;

   // Request decode.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_mod    = req_scancode inside {[hbkrb_pkg::MOD_FIRST : hbkrb_pkg::MOD_LAST]};
   assign is_key    = ({1'b0, req_scancode} < 9'(hbkrb_pkg::KEY_COUNT));
   assign ignored   = req_is_repeat || (!is_key && !is_mod);

   // Bitmap update at accept time; the scan starts the cycle after.
   always_comb begin
      map_wr.en   = accept && !ignored && is_key;
      map_wr.addr = KW'(req_scancode);
      map_wr.data = req_key_down;
   end

   hbkrb_keymap u_keymap (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign scan_end = dat_vld_ff && (dat_idx_ff == LAST_IDX);

   // Sequencer, scan collector and report output registers.
   always_comb begin
      state_in      = state_ff;
      synced_in     = synced_ff;
      lock_pend_in  = lock_pend_ff;
      caps_in       = caps_ff;
      num_in        = num_ff;
      mods_in       = mods_ff;
      ack_in        = ack_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      dat_vld_in    = 1'b0;
      dat_idx_in    = idx_ff;
      count_in      = count_ff;
      rollover_in   = rollover_ff;
      key_slot_in   = key_slot_ff;
      out_mods_in   = out_mods_ff;
      out_slot_in   = out_slot_ff;
      out_ack_in    = out_ack_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            // Latch the event and arm the scan.
            if (accept && !ignored) begin
               synced_in     = 1'b1;
               lock_pend_in  = !synced_ff && (req_caps_lock_on || req_num_lock_on);
               caps_in       = req_caps_lock_on;
               num_in        = req_num_lock_on;
               mods_in       = req_modifier_bits;
               ack_in        = req_ack_wait;
               idx_in        = '0;
               issue_done_in = 1'b0;
               count_in      = '0;
               rollover_in   = 1'b0;
               for (int s = 0; s < SP; s++) begin
                  key_slot_in[s] = hbkrb_pkg::EMPTY_CODE;
               end
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one bitmap read per cycle.
            if (!issue_done_ff) begin
               dat_vld_in = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            // Shared compare: place the pressed key or flag rollover.
            if (dat_vld_ff && rd_data) begin
               if (count_ff == CW'(hbkrb_pkg::REPORT_SLOTS)) begin
                  rollover_in = 1'b1;
               end else begin
                  for (int s = 0; s < SP; s++) begin
                     if (s < hbkrb_pkg::REPORT_SLOTS && count_ff == CW'(s)) begin
                        key_slot_in[s] = hbkrb_pkg::code_type'(dat_idx_ff);
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            // Scan finished: load the first report.
            if (scan_end) begin
               if (lock_pend_ff) begin
                  out_mods_in = '0;
                  for (int s = 0; s < SP; s++) begin
                     out_slot_in[s] = hbkrb_pkg::lock_slot(s, caps_ff, num_ff);
                  end
                  out_ack_in  = '0;
                  out_last_in = 1'b0;
                  state_in    = ST_LOCK;
               end else begin
                  out_mods_in = mods_ff;
                  for (int s = 0; s < SP; s++) begin
                     if (s >= hbkrb_pkg::REPORT_SLOTS) begin
                        out_slot_in[s] = hbkrb_pkg::EMPTY_CODE;
                     end else if (rollover_in) begin
                        out_slot_in[s] = hbkrb_pkg::ROLLOVER_CODE;
                     end else begin
                        out_slot_in[s] = key_slot_in[s];
                     end
                  end
                  out_ack_in  = ack_ff;
                  out_last_in = 1'b1;
                  state_in    = ST_KEY;
               end
            end
         end
         ST_LOCK: begin
            // Lock report taken: follow with the key report.
            if (rsp_ready) begin
               out_mods_in = mods_ff;
               for (int s = 0; s < SP; s++) begin
                  if (s >= hbkrb_pkg::REPORT_SLOTS) begin
                     out_slot_in[s] = hbkrb_pkg::EMPTY_CODE;
                  end else if (rollover_ff) begin
                     out_slot_in[s] = hbkrb_pkg::ROLLOVER_CODE;
                  end else begin
                     out_slot_in[s] = key_slot_ff[s];
                  end
               end
               out_ack_in   = ack_ff;
               out_last_in  = 1'b1;
               lock_pend_in = 1'b0;
               state_in     = ST_KEY;
            end
         end
         ST_KEY: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         synced_ff     <= 1'b0;
         lock_pend_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
         dat_vld_ff    <= 1'b0;
         count_ff      <= '0;
         rollover_ff   <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         synced_ff     <= synced_in;
         lock_pend_ff  <= lock_pend_in;
         issue_done_ff <= issue_done_in;
         dat_vld_ff    <= dat_vld_in;
         count_ff      <= count_in;
         rollover_ff   <= rollover_in;
         idx_ff        <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      caps_ff     <= caps_in;
      num_ff      <= num_in;
      mods_ff     <= mods_in;
      ack_ff      <= ack_in;
      dat_idx_ff  <= dat_idx_in;
      key_slot_ff <= key_slot_in;
      out_mods_ff <= out_mods_in;
      out_slot_ff <= out_slot_in;
      out_ack_ff  <= out_ack_in;
      out_last_ff <= out_last_in;
   end

   // Report outputs.
   assign rsp_valid            = (state_ff == ST_LOCK) || (state_ff == ST_KEY);
   assign rsp_report_modifiers = out_mods_ff;
   assign rsp_slot0            = out_slot_ff[0];
   assign rsp_slot1            = out_slot_ff[1];
   assign rsp_slot2            = out_slot_ff[2];
   assign rsp_slot3            = out_slot_ff[3];
   assign rsp_slot4            = out_slot_ff[4];
   assign rsp_slot5            = out_slot_ff[5];
   assign rsp_report_ack_wait  = out_ack_ff;
   assign rsp_last             = out_last_ff;

`ifndef SYNTH
   // A report is never offered while a new request can be taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("report valid while request ready");

   // The slot count never passes the number of report slots.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(hbkrb_pkg::REPORT_SLOTS))
      else $error("slot count out of range");

   // A delivered lock report is always followed by the key report.
   a_lock_then_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOCK) && rsp_ready |=> (state_ff == ST_KEY) && rsp_last)
      else $error("lock report not followed by key report");

   // A report that is not the last one is a lock report with zero modifier and ack wait fields.
   a_lock_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_report_modifiers == 8'h00)
                                  && (rsp_report_ack_wait == 64'd0))
      else $error("lock report carries modifiers or ack");

   // Lock synchronization is never undone.
   a_synced_sticky: assert property (@(posedge clock) disable iff (reset)
      synced_ff |=> synced_ff)
      else $error("lock sync flag cleared");
`endif

endmodule
